@@ rtl/core/u8u16_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

  // byte order mark bytes, in order
  localparam logic [7:0] MARK_B0 = 8'hEF;
  localparam logic [7:0] MARK_B1 = 8'hBB;
  localparam logic [7:0] MARK_B2 = 8'hBF;

  // mark_position value once all three mark bytes have matched
  localparam logic [1:0] MARK_DONE = 2'd3;

  // surrogate bases
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // lead byte classes (mask / match pairs)
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MATCH = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_MATCH = 8'hF0;

  // position inside a multi-byte sequence
  typedef enum logic [2:0] {
    PH_LEAD     = 3'd0,
    PH_TWO_B2   = 3'd1,
    PH_THREE_B2 = 3'd2,
    PH_THREE_B3 = 3'd3,
    PH_FOUR_B2  = 3'd4,
    PH_FOUR_B3  = 3'd5,
    PH_FOUR_B4  = 3'd6
  } phase_t;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  mark_position;
    logic        text_rejected;
    phase_t      sequence_phase;
    logic [15:0] partial_unit;
    logic [4:0]  plane_bits;
  } dec_state_t;

  // result of one byte step
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        bom_missing;
  } step_res_t;

endpackage

@@ rtl/core/u8u16_step.sv @@
// combinational per-byte update: mark check, utf-8 decode, next state
module u8u16_step (
  input  u8u16_pkg::dec_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output u8u16_pkg::dec_state_t nxt,
  output u8u16_pkg::step_res_t  res
);

  logic [7:0] mark_expect;
  logic       is_cont;
  logic       in_seq;
  logic [3:0] plane_m1;

  // expected mark byte at the current position
  always_comb begin
    case (cur.mark_position)
      2'd0:    mark_expect = u8u16_pkg::MARK_B0;
      2'd1:    mark_expect = u8u16_pkg::MARK_B1;
      default: mark_expect = u8u16_pkg::MARK_B2;
    endcase
  end

  assign is_cont  = (data_byte & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MATCH;
  assign in_seq   = is_cont && (cur.sequence_phase != u8u16_pkg::PH_LEAD);
  assign plane_m1 = 4'(cur.plane_bits - 5'd1);

  // next state and result
  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.text_rejected) begin
      // rest of a rejected text is skipped
    end else if (cur.mark_position != u8u16_pkg::MARK_DONE) begin
      if (data_byte == mark_expect) begin
        nxt.mark_position = cur.mark_position + 2'd1;
        if (last_byte && (cur.mark_position != 2'd2)) begin
          res.emit        = 1'b1;
          res.bom_missing = 1'b1;
        end
      end else begin
        nxt.text_rejected = 1'b1;
        res.emit          = 1'b1;
        res.bom_missing   = 1'b1;
      end
    end else if (!in_seq) begin
      // byte taken as a lead byte; a broken sequence is dropped
      nxt.sequence_phase = u8u16_pkg::PH_LEAD;
      if (!data_byte[7]) begin
        res.emit      = 1'b1;
        res.code_unit = {8'h00, data_byte};
      end else if ((data_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_MATCH) begin
        nxt.partial_unit   = {5'd0, data_byte[4:0], 6'd0};
        nxt.sequence_phase = u8u16_pkg::PH_TWO_B2;
      end else if ((data_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_MATCH) begin
        nxt.partial_unit   = {data_byte[3:0], 12'd0};
        nxt.sequence_phase = u8u16_pkg::PH_THREE_B2;
      end else if ((data_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_MATCH) begin
        nxt.plane_bits     = {data_byte[2:0], 2'd0};
        nxt.partial_unit   = '0;
        nxt.sequence_phase = u8u16_pkg::PH_FOUR_B2;
      end
    end else begin
      case (cur.sequence_phase)
        u8u16_pkg::PH_TWO_B2, u8u16_pkg::PH_THREE_B3: begin
          res.emit           = 1'b1;
          res.code_unit      = cur.partial_unit | {10'd0, data_byte[5:0]};
          nxt.sequence_phase = u8u16_pkg::PH_LEAD;
        end
        u8u16_pkg::PH_THREE_B2: begin
          nxt.partial_unit   = cur.partial_unit | {4'd0, data_byte[5:0], 6'd0};
          nxt.sequence_phase = u8u16_pkg::PH_THREE_B3;
        end
        u8u16_pkg::PH_FOUR_B2: begin
          nxt.plane_bits     = cur.plane_bits | {3'd0, data_byte[5:4]};
          nxt.partial_unit   = {10'd0, data_byte[3:0], 2'd0};
          nxt.sequence_phase = u8u16_pkg::PH_FOUR_B3;
        end
        u8u16_pkg::PH_FOUR_B3: begin
          // high surrogate goes out at the third byte
          res.emit           = 1'b1;
          res.code_unit      = u8u16_pkg::HI_SURR_BASE | {6'd0, plane_m1, 6'd0}
                               | cur.partial_unit | {14'd0, data_byte[5:4]};
          nxt.partial_unit   = {6'd0, data_byte[3:0], 6'd0};
          nxt.sequence_phase = u8u16_pkg::PH_FOUR_B4;
        end
        u8u16_pkg::PH_FOUR_B4: begin
          res.emit           = 1'b1;
          res.code_unit      = u8u16_pkg::LO_SURR_BASE | cur.partial_unit
                               | {10'd0, data_byte[5:0]};
          nxt.sequence_phase = u8u16_pkg::PH_LEAD;
        end
        default: begin
          nxt.sequence_phase = u8u16_pkg::PH_LEAD;
        end
      endcase
    end
    // end of text: back to the mark check
    if (last_byte) begin
      nxt = '0;
    end
  end

endmodule

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// top level of the utf-8 to utf-16 decoder: state and output registers
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------
//  byte    | byte_valid / byte_ready  | data_byte[7:0], last_byte
//  unit    | unit_valid / unit_ready  | code_unit[15:0], bom_missing
//
// one byte per cycle while byte_ready is high; a result appears on the unit
// channel the cycle after its byte is taken, from the output register.
// byte_ready is high whenever the output register is empty or being drained.
// rst (synchronous) clears the decoder state and the output valid.
// a stall on unit_ready holds the result and stops byte intake only then.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        unit_valid,
  input  logic        unit_ready,
  output logic [15:0] code_unit,
  output logic        bom_missing
);

  u8u16_pkg::dec_state_t state;
  u8u16_pkg::dec_state_t state_next;
  u8u16_pkg::step_res_t  step_res;
  logic                  byte_take;

  assign byte_ready = !unit_valid || unit_ready;
  assign byte_take  = byte_valid && byte_ready;

  u8u16_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .nxt       (state_next),
    .res       (step_res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (byte_take) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (byte_take) begin
      unit_valid <= step_res.emit;
    end else if (unit_ready) begin
      unit_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (byte_take && step_res.emit) begin
      code_unit   <= step_res.code_unit;
      bom_missing <= step_res.bom_missing;
    end
  end

endmodule

@@ rtl/core/u8u16_chk.sv @@
// port-level checker for the utf-8 to utf-16 decoder, bound to the top level
module u8u16_chk (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        unit_valid,
  input logic        unit_ready,
  input logic [15:0] code_unit,
  input logic        bom_missing
);

  // a missing-mark result carries a zero code unit
  a_bom_zero: assert property (@(posedge clk) disable iff (rst)
    unit_valid && bom_missing |-> code_unit == 16'd0)
    else $error("bom_missing result with nonzero code_unit");

  // empty output register never blocks intake
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !unit_valid |-> byte_ready)
    else $error("byte_ready low with empty output");

  // nothing is shown right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !unit_valid)
    else $error("unit_valid high after reset");

  // a stalled result holds until its transaction completes
  a_unit_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_ready |=> unit_valid && $stable(code_unit)
      && $stable(bom_missing))
    else $error("stalled result changed");

endmodule

bind utf8_to_utf16_decoder u8u16_chk u_chk (.*);

@@ bench/tb_utf8_to_utf16_decoder.sv @@
// testbench for the utf-8 to utf-16 decoder: directed table, random texts, scoreboard
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 225;
  localparam int DRAIN_CYCLES = 8;

  // one byte of text as offered on the byte channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  // one expected code unit transaction
  typedef struct packed {
    logic [15:0] unit;
    logic        bom;
  } unit_exp_t;

  // directed row: byte, last flag, typed expectation (when typed is set)
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic        has_unit;
    logic [15:0] unit;
    logic        bom;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // text with a good mark: extremes, all lengths, strays, retry, partial at end
    '{8'hEF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBB, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 1'b1, 16'h007F, 1'b0},
    '{8'hC2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // four-byte sequence in plane zero
    '{8'hF0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // stray continuation and invalid lead byte
    '{8'h80, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    // failed continuation retried as lead
    '{8'hC2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // partial character at the last byte
    '{8'hE2, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    // mark mismatch on the first byte
    '{8'h41, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1},
    // text ends inside the mark
    '{8'hEF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBB, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1},
    // mismatch on the second byte, rest ignored
    '{8'hEF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}
  };

  localparam logic [7:0] MARK_SEQ [3] = '{u8u16_pkg::MARK_B0, u8u16_pkg::MARK_B1,
                                          u8u16_pkg::MARK_B2};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        unit_valid;
  logic        unit_ready = 1'b0;
  logic [15:0] code_unit;
  logic        bom_missing;

  utf8_to_utf16_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .code_unit   (code_unit),
    .bom_missing (bom_missing)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [1:0]        dec_mark = '0;
  logic              dec_reject = 1'b0;
  u8u16_pkg::phase_t dec_phase = u8u16_pkg::PH_LEAD;
  logic [15:0]       dec_part = '0;
  logic [4:0]        dec_plane = '0;

  unit_exp_t   expected_units [$];
  text_byte_t  text_bytes [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;

  // predict the code unit produced by one byte, advancing the decoder state
  function void decode_step(input logic [7:0] b, input logic l,
                            output bit emit, output unit_exp_t res);
    logic       cont;
    logic [4:0] plane_m1;
    emit = 1'b0;
    res = '0;
    cont = (b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_MATCH;
    plane_m1 = dec_plane - 5'd1;
    if (dec_reject) begin
      // rest of a rejected text is ignored
    end else if (dec_mark != u8u16_pkg::MARK_DONE) begin
      if (b == MARK_SEQ[dec_mark]) begin
        dec_mark = dec_mark + 2'd1;
        if (l && dec_mark != u8u16_pkg::MARK_DONE) begin
          emit = 1'b1;
          res.bom = 1'b1;
        end
      end else begin
        dec_reject = 1'b1;
        emit = 1'b1;
        res.bom = 1'b1;
      end
    end else if (!cont || dec_phase == u8u16_pkg::PH_LEAD) begin
      // lead byte position
      dec_phase = u8u16_pkg::PH_LEAD;
      if (!b[7]) begin
        emit = 1'b1;
        res.unit = {8'h00, b};
      end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_MATCH) begin
        dec_part = {5'b0, b[4:0], 6'b0};
        dec_phase = u8u16_pkg::PH_TWO_B2;
      end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_MATCH) begin
        dec_part = {b[3:0], 12'b0};
        dec_phase = u8u16_pkg::PH_THREE_B2;
      end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_MATCH) begin
        dec_plane = {b[2:0], 2'b0};
        dec_part = '0;
        dec_phase = u8u16_pkg::PH_FOUR_B2;
      end
    end else begin
      case (dec_phase)
        u8u16_pkg::PH_TWO_B2, u8u16_pkg::PH_THREE_B3: begin
          emit = 1'b1;
          res.unit = dec_part | {10'b0, b[5:0]};
          dec_phase = u8u16_pkg::PH_LEAD;
        end
        u8u16_pkg::PH_THREE_B2: begin
          dec_part = dec_part | {4'b0, b[5:0], 6'b0};
          dec_phase = u8u16_pkg::PH_THREE_B3;
        end
        u8u16_pkg::PH_FOUR_B2: begin
          dec_plane = dec_plane | {3'b0, b[5:4]};
          dec_part = {10'b0, b[3:0], 2'b0};
          dec_phase = u8u16_pkg::PH_FOUR_B3;
        end
        u8u16_pkg::PH_FOUR_B3: begin
          // high surrogate goes out at the third byte
          emit = 1'b1;
          res.unit = u8u16_pkg::HI_SURR_BASE | {6'b0, plane_m1[3:0], 6'b0}
                     | dec_part | {14'b0, b[5:4]};
          dec_part = {6'b0, b[3:0], 6'b0};
          dec_phase = u8u16_pkg::PH_FOUR_B4;
        end
        default: begin
          emit = 1'b1;
          res.unit = u8u16_pkg::LO_SURR_BASE | dec_part | {10'b0, b[5:0]};
          dec_phase = u8u16_pkg::PH_LEAD;
        end
      endcase
    end
    // end of text returns to the mark check
    if (l) begin
      dec_mark = '0;
      dec_reject = 1'b0;
      dec_phase = u8u16_pkg::PH_LEAD;
      dec_part = '0;
      dec_plane = '0;
    end
  endfunction

  // offer one byte, wait for its transaction, then queue its expectation
  task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                           input logic t_has, input unit_exp_t t_res);
    bit        emit;
    unit_exp_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_step(d, l, emit, res);
    if (typed) begin
      emit = t_has;
      res = t_res;
    end
    if (emit) expected_units.push_back(res);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // append one random text, mostly well formed, ending with last set
  function automatic void gen_text();
    int mark_kind;
    int chars;
    int kind;
    int need;
    int start;
    start = text_bytes.size();
    mark_kind = $urandom_range(99);
    chars = $urandom_range(1, 12);
    if (mark_kind < 80) begin
      text_bytes.push_back('{u8u16_pkg::MARK_B0, 1'b0});
      text_bytes.push_back('{u8u16_pkg::MARK_B1, 1'b0});
      text_bytes.push_back('{u8u16_pkg::MARK_B2, 1'b0});
    end else if (mark_kind < 88) begin
      // broken mark: good prefix then a random byte
      text_bytes.push_back('{u8u16_pkg::MARK_B0, 1'b0});
      if ($urandom_range(1)) text_bytes.push_back('{u8u16_pkg::MARK_B1, 1'b0});
      text_bytes.push_back('{8'($urandom_range(255)), 1'b0});
    end else if (mark_kind < 94) begin
      // text ends inside the mark
      text_bytes.push_back('{u8u16_pkg::MARK_B0, 1'b0});
      if ($urandom_range(1)) text_bytes.push_back('{u8u16_pkg::MARK_B1, 1'b0});
      chars = 0;
    end
    for (int i = 0; i < chars; i++) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: text_bytes.push_back('{8'($urandom_range(127)), 1'b0});
        3, 4: begin
          text_bytes.push_back('{{3'b110, 5'($urandom_range(31))}, 1'b0});
          text_bytes.push_back('{cont_byte(), 1'b0});
        end
        5, 6: begin
          text_bytes.push_back('{{4'b1110, 4'($urandom_range(15))}, 1'b0});
          text_bytes.push_back('{cont_byte(), 1'b0});
          text_bytes.push_back('{cont_byte(), 1'b0});
        end
        7, 8: begin
          text_bytes.push_back('{{5'b11110, 3'($urandom_range(7))}, 1'b0});
          repeat (3) text_bytes.push_back('{cont_byte(), 1'b0});
        end
        default: begin
          // noise: a random byte or a truncated sequence
          if ($urandom_range(1)) begin
            text_bytes.push_back('{8'($urandom_range(255)), 1'b0});
          end else begin
            need = $urandom_range(1, 3);
            case (need)
              1: text_bytes.push_back('{{3'b110, 5'($urandom_range(31))}, 1'b0});
              2: text_bytes.push_back('{{4'b1110, 4'($urandom_range(15))}, 1'b0});
              default: text_bytes.push_back('{{5'b11110, 3'($urandom_range(7))}, 1'b0});
            endcase
            repeat ($urandom_range(0, need - 1)) text_bytes.push_back('{cont_byte(), 1'b0});
          end
        end
      endcase
    end
    if (text_bytes.size() == start) text_bytes.push_back('{8'($urandom_range(255)), 1'b0});
    text_bytes[text_bytes.size() - 1].last = 1'b1;
  endfunction

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      unit_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      unit_ready <= 1'b0;
    end else begin
      unit_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each unit transaction against the oldest expectation
  always @(posedge clk) begin
    unit_exp_t want;
    if (!rst && unit_valid && unit_ready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected transaction, actual unit %h bom %b",
                 $realtime, code_unit, bom_missing);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_units.pop_front();
        if (code_unit !== want.unit || bom_missing !== want.bom) begin
          $display("%0t: mismatch, expected unit %h bom %b, actual unit %h bom %b",
                   $realtime, want.unit, want.bom, code_unit, bom_missing);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    text_byte_t tb_item;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(DIR_TABLE[r].data, DIR_TABLE[r].last, DIR_TABLE[r].typed,
                DIR_TABLE[r].has_unit, '{DIR_TABLE[r].unit, DIR_TABLE[r].bom});
    end
    wait_drained();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      text_bytes.delete();
      while (text_bytes.size() < PHASE_BYTES) gen_text();
      if (ph == 0) hold_go <= 1'b1;
      while (text_bytes.size() != 0) begin
        tb_item = text_bytes.pop_front();
        send_byte(tb_item.data, tb_item.last, 1'b0, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
